/* src/pisc_pkg.sv */
// ----------------------------------------------------------------------------
// pisc_pkg: shared definitions for the point-in-segment-cylinder test
// coordinate width default and configuration register indexes
// ----------------------------------------------------------------------------
package pisc_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int CFG_IDX_W       = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_END_A_X = 3'd0,
        REG_END_A_Y = 3'd1,
        REG_END_A_Z = 3'd2,
        REG_END_B_X = 3'd3,
        REG_END_B_Y = 3'd4,
        REG_END_B_Z = 3'd5,
        REG_RADIUS  = 3'd6
    } t_cfg_reg;

endpackage

/* src/pisc_cfg.sv */
// ----------------------------------------------------------------------------
// pisc_cfg: configuration registers and derived axis terms
// holds the axis end points and radius, and builds u = b - a and the
// distance limit r^2 * |u|^2 over a short register chain
// ----------------------------------------------------------------------------
module pisc_cfg #(
    parameter int COORD_WIDTH = pisc_pkg::COORD_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pisc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]           i_cfg_data,
    output logic signed [COORD_WIDTH-1:0]    o_end_a [3],
    output logic signed [COORD_WIDTH-1:0]    o_end_b [3],
    output logic signed [COORD_WIDTH:0]      o_u [3],
    output logic [4*COORD_WIDTH-1:0]         o_lim
);

    localparam int DW   = COORD_WIDTH + 1;
    localparam int PW   = 2 * DW;
    localparam int L2W  = PW;
    localparam int RW   = COORD_WIDTH - 1;
    localparam int R2W  = 2 * RW;
    localparam int K2   = DW;
    localparam int RHW  = R2W - K2;
    localparam int MIDW = 2 * K2 + 1;
    localparam int LMW  = R2W + L2W;

    logic signed [COORD_WIDTH-1:0] r_a [3];
    logic signed [COORD_WIDTH-1:0] r_b [3];
    logic [RW-1:0]                 r_radius;

    logic signed [DW-1:0]  r_u [3];
    logic signed [PW-1:0]  r_uu [3];
    logic [L2W-1:0]        r_len2;
    logic [R2W-1:0]        r_r2;
    logic [RHW+K2-1:0]     r_phh;
    logic [RHW+K2-1:0]     r_phl;
    logic [2*K2-1:0]       r_plh;
    logic [2*K2-1:0]       r_pll;
    logic [MIDW-1:0]       r_mid;
    logic [R2W-1:0]        r_hi;
    logic [2*K2-1:0]       r_lo;
    logic [LMW-1:0]        r_lim;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_a[i] <= '0;
                r_b[i] <= '0;
            end
            r_radius <= '0;
        end else if (i_cfg_we) begin
            unique case (pisc_pkg::t_cfg_reg'(i_cfg_idx))
                pisc_pkg::REG_END_A_X: r_a[0] <= i_cfg_data;
                pisc_pkg::REG_END_A_Y: r_a[1] <= i_cfg_data;
                pisc_pkg::REG_END_A_Z: r_a[2] <= i_cfg_data;
                pisc_pkg::REG_END_B_X: r_b[0] <= i_cfg_data;
                pisc_pkg::REG_END_B_Y: r_b[1] <= i_cfg_data;
                pisc_pkg::REG_END_B_Z: r_b[2] <= i_cfg_data;
                pisc_pkg::REG_RADIUS:  r_radius <= i_cfg_data[RW-1:0];
                default: ;
            endcase
        end
    end

    // derived terms, refreshed every cycle
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_u[i]  <= DW'(r_b[i]) - DW'(r_a[i]);
            r_uu[i] <= PW'(r_u[i]) * PW'(r_u[i]);
        end
        r_len2 <= r_uu[0][L2W-1:0] + r_uu[1][L2W-1:0] + r_uu[2][L2W-1:0];
        r_r2   <= R2W'(r_radius) * R2W'(r_radius);
        // split product, halves at K2
        r_phh  <= (RHW+K2)'(r_r2[R2W-1:K2]) * (RHW+K2)'(r_len2[L2W-1:K2]);
        r_phl  <= (RHW+K2)'(r_r2[R2W-1:K2]) * (RHW+K2)'(r_len2[K2-1:0]);
        r_plh  <= (2*K2)'(r_r2[K2-1:0]) * (2*K2)'(r_len2[L2W-1:K2]);
        r_pll  <= (2*K2)'(r_r2[K2-1:0]) * (2*K2)'(r_len2[K2-1:0]);
        r_mid  <= MIDW'(r_phl) + MIDW'(r_plh);
        r_hi   <= r_phh;
        r_lo   <= r_pll;
        r_lim  <= {r_hi, r_lo} + (LMW'(r_mid) << K2);
    end

    assign o_end_a = r_a;
    assign o_end_b = r_b;
    assign o_u     = r_u;
    assign o_lim   = r_lim;

endmodule

/* src/point_in_segment_cylinder_test_unit.sv */
// ----------------------------------------------------------------------------
// point_in_segment_cylinder_test_unit: point in finite cylinder test
// path: each input beat is registered in every stage in turn and leaves from the last
// throughput: one beat per cycle; input stall rises only when all 8 stages
//   hold a beat and the output is stalled
// config: written while idle; after a write the derived limit settles through the u, |u|^2 and product registers
// reset: synchronous active low, clears stage valid bits and the configuration registers
// ----------------------------------------------------------------------------
module point_in_segment_cylinder_test_unit #(
    parameter int COORD_WIDTH = pisc_pkg::COORD_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [pisc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]           i_cfg_data,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [COORD_WIDTH-1:0]    i_point_x,
    input  logic signed [COORD_WIDTH-1:0]    i_point_y,
    input  logic signed [COORD_WIDTH-1:0]    i_point_z,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_inside_res
);

    // widths follow the coordinate width
    localparam int DW   = COORD_WIDTH + 1;   // coordinate differences
    localparam int PW   = 2 * DW;            // single products
    localparam int SW   = PW + 2;            // dot product sums
    localparam int CW   = PW + 1;            // cross product components
    localparam int MW   = CW;                // cross component magnitude
    localparam int K    = (MW + 1) / 2;      // low half of the magnitude
    localparam int HW   = MW - K;            // high half
    localparam int QW   = 2 * MW;            // squared component
    localparam int C2W  = QW + 2;            // |u x v|^2
    localparam int LMW  = 4 * COORD_WIDTH;   // r^2 |u|^2
    localparam int NST  = 8;                 // pipeline depth

    // configuration and derived axis terms
    logic signed [COORD_WIDTH-1:0] w_a [3];
    logic signed [COORD_WIDTH-1:0] w_b [3];
    logic signed [DW-1:0]          w_u [3];
    logic [LMW-1:0]                w_lim;

    pisc_cfg #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_end_a    (w_a),
        .o_end_b    (w_b),
        .o_u        (w_u),
        .o_lim      (w_lim)
    );

    // stage valids and per-stage advance
    logic [NST:1] r_vld;
    logic [NST:1] w_en;
    logic         w_acc_in;
    logic         w_acc_out;

    // a stage advances when empty or when the stage after it advances,
    // so bubbles collapse under a stalled output
    always_comb begin
        w_en[NST] = !r_vld[NST] || !i_out_stall;
        for (int k = NST - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_in_stall = !w_en[1];
    assign w_acc_in   = i_in_valid && w_en[1];
    assign w_acc_out  = r_vld[NST] && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: v = p - a and bp = b - p
    logic signed [COORD_WIDTH-1:0] w_p [3];
    logic signed [DW-1:0]          r1_v  [3];
    logic signed [DW-1:0]          r1_bp [3];

    assign w_p[0] = i_point_x;
    assign w_p[1] = i_point_y;
    assign w_p[2] = i_point_z;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r1_v[i]  <= DW'(w_p[i]) - DW'(w_a[i]);
                r1_bp[i] <= DW'(w_b[i]) - DW'(w_p[i]);
            end
        end
    end

    // stage 2: all single products
    // dot terms u.v and u.bp; cross terms as left and right products
    logic signed [PW-1:0] r2_dv [3];
    logic signed [PW-1:0] r2_db [3];
    logic signed [PW-1:0] r2_xa [3];
    logic signed [PW-1:0] r2_xb [3];

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            for (int i = 0; i < 3; i++) begin
                r2_dv[i] <= PW'(w_u[i]) * PW'(r1_v[i]);
                r2_db[i] <= PW'(w_u[i]) * PW'(r1_bp[i]);
            end
            // cx = u1 v2 - u2 v1, cy = u2 v0 - u0 v2, cz = u0 v1 - u1 v0
            r2_xa[0] <= PW'(w_u[1]) * PW'(r1_v[2]);
            r2_xb[0] <= PW'(w_u[2]) * PW'(r1_v[1]);
            r2_xa[1] <= PW'(w_u[2]) * PW'(r1_v[0]);
            r2_xb[1] <= PW'(w_u[0]) * PW'(r1_v[2]);
            r2_xa[2] <= PW'(w_u[0]) * PW'(r1_v[1]);
            r2_xb[2] <= PW'(w_u[1]) * PW'(r1_v[0]);
        end
    end

    // stage 3: dot sums reduced to the end cap flag, cross components
    // (a-b).(a-p) equals u.v, so both cap tests are u.v > 0 and u.bp > 0
    logic signed [SW-1:0] w_d1;
    logic signed [SW-1:0] w_d2;
    logic                 r3_caps;
    logic signed [CW-1:0] r3_c [3];

    assign w_d1 = SW'(r2_dv[0]) + SW'(r2_dv[1]) + SW'(r2_dv[2]);
    assign w_d2 = SW'(r2_db[0]) + SW'(r2_db[1]) + SW'(r2_db[2]);

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_caps <= !w_d1[SW-1] && (w_d1 != '0) && !w_d2[SW-1] && (w_d2 != '0);
            for (int i = 0; i < 3; i++) begin
                r3_c[i] <= CW'(r2_xa[i]) - CW'(r2_xb[i]);
            end
        end
    end

    // stage 4: magnitudes of the cross components
    logic          r4_caps;
    logic [MW-1:0] r4_mag [3];

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_caps <= r3_caps;
            for (int i = 0; i < 3; i++) begin
                r4_mag[i] <= r3_c[i][CW-1] ? MW'(-r3_c[i]) : MW'(r3_c[i]);
            end
        end
    end

    // stage 5: squares split into half-width partial products
    logic               r5_caps;
    logic [2*HW-1:0]    r5_hh [3];
    logic [HW+K-1:0]    r5_hl [3];
    logic [2*K-1:0]     r5_ll [3];

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_caps <= r4_caps;
            for (int i = 0; i < 3; i++) begin
                r5_hh[i] <= (2*HW)'(r4_mag[i][MW-1:K]) * (2*HW)'(r4_mag[i][MW-1:K]);
                r5_hl[i] <= (HW+K)'(r4_mag[i][MW-1:K]) * (HW+K)'(r4_mag[i][K-1:0]);
                r5_ll[i] <= (2*K)'(r4_mag[i][K-1:0]) * (2*K)'(r4_mag[i][K-1:0]);
            end
        end
    end

    // stage 6: recombine, m^2 = hh << 2k + hl << (k+1) + ll
    logic          r6_caps;
    logic [QW-1:0] r6_sq [3];

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_caps <= r5_caps;
            for (int i = 0; i < 3; i++) begin
                r6_sq[i] <= (QW'(r5_hh[i]) << (2*K)) + (QW'(r5_hl[i]) << (K+1))
                          + QW'(r5_ll[i]);
            end
        end
    end

    // stage 7: |u x v|^2
    logic           r7_caps;
    logic [C2W-1:0] r7_c2;

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r7_caps <= r6_caps;
            r7_c2   <= C2W'(r6_sq[0]) + C2W'(r6_sq[1]) + C2W'(r6_sq[2]);
        end
    end

    // stage 8: radial compare against the limit, output register
    // a degenerate axis or zero radius gives a zero limit and a false result
    logic r8_res;

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r8_res <= r7_caps && (r7_c2 < C2W'(w_lim));
        end
    end

    assign o_out_valid  = r_vld[NST];
    assign o_inside_res = r8_res;

    // beats in flight change only by what enters and leaves
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ($countones(r_vld) == $countones($past(r_vld))
                  + int'($past(w_acc_in)) - int'($past(w_acc_out))))
        else $error("pipeline occupancy mismatch");

    // input stalls only when every stage holds a beat and the output is stalled
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> ((&r_vld) && i_out_stall))
        else $error("input stalled with room in the pipeline");

    // a point outside the end caps never reports inside
    a_caps_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[7] && w_en[8] && !r7_caps) |=> !o_inside_res)
        else $error("inside reported outside the end caps");

endmodule
